// ===== rtl/integer_to_decimal_ascii_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer to decimal ASCII converter
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_DECIMAL_ASCII_MACROS_SVH
`define INTEGER_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define I2DA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define I2DA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define I2DA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define I2DA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/i2da_pkg.sv =====
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants of the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

   // Input field width and widest supported value width
   localparam int IN_BITS        = 32;
   localparam int MAX_BITS       = 64;
   localparam int VALUE_BITS_DEF = 32;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Input item
   typedef struct packed {
      logic [IN_BITS-1:0] value;
      logic               is_signed;
   } req_type;

   // Result item: one character
   typedef struct packed {
      logic [7:0] text_char;
      logic       last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic shift_digit;
      logic show_sign;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_bit;
      logic top_zero;
      logic one_left;
      logic neg;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/i2da_datapath.sv =====
// ----------------------------------------------------------------------------
// i2da_datapath
// Magnitude register, double-dabble BCD register, bit and digit counters,
// and the character formatting of the result item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_to_decimal_ascii_macros.svh"

module i2da_datapath #(
   parameter int VALUE_BITS = i2da_pkg::VALUE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire i2da_pkg::req_type    req_data,
   input  wire i2da_pkg::cmd_type    cmd,
   output i2da_pkg::status_type      status,
   output i2da_pkg::rsp_type         rsp_data
);
   import i2da_pkg::*;

   // Decimal digits of the largest unsigned value: floor(VB*log10(2)) + 1
   localparam int DIGITS   = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_BITS = DIGITS * 4;
   localparam int DCW      = $clog2(DIGITS + 1);
   localparam int BCW      = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCW-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [DCW-1:0]        digits_left_ff, digits_left_in;
   logic                  neg_ff, neg_in;

   logic [MAX_BITS-1:0]   value_wide;
   logic [VALUE_BITS-1:0] value_v;
   logic                  value_neg;
   logic [BCD_BITS-1:0]   bcd_adj;
   logic [3:0]            top_digit;

   // Operand: masked or zero-extended to VALUE_BITS, magnitude taken if negative
   assign value_wide = {{(MAX_BITS-IN_BITS){1'b0}}, req_data.value};
   assign value_v    = value_wide[VALUE_BITS-1:0];
   assign value_neg  = req_data.is_signed & value_v[VALUE_BITS-1];

   // Add 3 to each digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: 4];

   // Next values of the datapath registers
   always_comb begin
      mag_in         = mag_ff;
      bcd_in         = bcd_ff;
      bit_cnt_in     = bit_cnt_ff;
      digits_left_in = digits_left_ff;
      neg_in         = neg_ff;
      if (cmd.load) begin
         mag_in         = value_neg ? (~value_v + {{(VALUE_BITS-1){1'b0}}, 1'b1})
                                    : value_v;
         bcd_in         = '0;
         bit_cnt_in     = BCW'(VALUE_BITS);
         digits_left_in = DCW'(DIGITS);
         neg_in         = value_neg;
      end else if (cmd.step) begin
         bcd_in     = {bcd_adj[BCD_BITS-2:0], mag_ff[VALUE_BITS-1]};
         mag_in     = {mag_ff[VALUE_BITS-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - BCW'(1);
      end else if (cmd.shift_digit) begin
         bcd_in         = {bcd_ff[BCD_BITS-5:0], 4'd0};
         digits_left_in = digits_left_ff - DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff         <= mag_in;
      bcd_ff         <= bcd_in;
      bit_cnt_ff     <= bit_cnt_in;
      digits_left_ff <= digits_left_in;
      neg_ff         <= neg_in;
   end

   // Status to the controller
   assign status.last_bit = (bit_cnt_ff == BCW'(1));
   assign status.top_zero = (top_digit == 4'd0);
   assign status.one_left = (digits_left_ff == DCW'(1));
   assign status.neg      = neg_ff;

   // Result item: minus sign or the top digit in ASCII
   assign rsp_data.text_char = cmd.show_sign ? CHAR_MINUS : (CHAR_ZERO | {4'd0, top_digit});
   assign rsp_data.last      = ~cmd.show_sign & status.one_left;

   // After the final shift every magnitude bit has moved into the BCD register
   `I2DA_ASSERT_NEXT(a_mag_drained, clock, reset, cmd.step && status.last_bit, mag_ff == '0)
   // Digits leaving the register are always decimal
   `I2DA_ASSERT_IMPLIES(a_digit_decimal, clock, reset, cmd.shift_digit, top_digit <= 4'd9)
   // Load and conversion never overlap with a digit shift
   `I2DA_ASSERT_IMPLIES(a_cmd_exclusive, clock, reset, cmd.load || cmd.step, !cmd.shift_digit)

endmodule

`default_nettype wire

// ===== rtl/i2da_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2da_ctrl
// Sequencer: accept, convert, drop leading zeros, emit sign and digits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_to_decimal_ascii_macros.svh"

module i2da_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire i2da_pkg::status_type  status,
   output i2da_pkg::cmd_type          cmd
);
   import i2da_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      show_sign_ff, show_sign_in;

   // Next state, registered outputs and commands
   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      show_sign_in    = show_sign_ff;
      cmd             = '0;
      cmd.show_sign   = show_sign_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.step = 1'b1;
            if (status.last_bit) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // Skip leading zeros, keeping at least one digit
            if (status.top_zero && !status.one_left) begin
               cmd.shift_digit = 1'b1;
            end else begin
               state_in     = status.neg ? ST_SIGN : ST_EMIT;
               rsp_valid_in = 1'b1;
               show_sign_in = status.neg;
            end
         end
         ST_SIGN: begin
            if (!rsp_stall) begin
               state_in     = ST_EMIT;
               show_sign_in = 1'b0;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (status.one_left) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b0;
               end else begin
                  cmd.shift_digit = 1'b1;
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
            show_sign_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         show_sign_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         show_sign_ff <= show_sign_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // An accepted item starts conversion, not output
   `I2DA_ASSERT_NEXT(a_accept_converts, clock, reset, req_valid && !req_stall, !rsp_valid_ff)
   // No new item is taken while characters are pending
   `I2DA_ASSERT_IMPLIES(a_busy_while_out, clock, reset, rsp_valid_ff, req_stall)
   // A minus sign is followed by a digit, never by the end of the item
   `I2DA_ASSERT_NEXT(a_sign_then_digit, clock, reset,
      rsp_valid_ff && show_sign_ff && !rsp_stall, rsp_valid_ff && !show_sign_ff)

endmodule

`default_nettype wire

// ===== rtl/integer_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts a binary number, signed or unsigned, to its decimal ASCII text.
// ----------------------------------------------------------------------------
// One item at a time. After an item is accepted the magnitude is shifted
// through a double-dabble BCD register, one bit per cycle, leading zero
// digits are then dropped one per cycle, and the characters follow one per
// cycle while the output is not stalled: a '-' for a negative signed value,
// then the digits, the last marked. The input is stalled until the final
// character of the current item has been taken.
`default_nettype none

module integer_to_decimal_ascii #(
   parameter int VALUE_BITS = i2da_pkg::VALUE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire i2da_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output i2da_pkg::rsp_type      rsp_data
);
   import i2da_pkg::*;

   cmd_type    cmd;
   status_type status;

   i2da_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   i2da_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== dv/integer_to_decimal_ascii_test.sv =====
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_test
// Self-checking bench for the binary to decimal ASCII converter. A table of
// edge numbers runs first, then randomized numbers biased toward digit-count
// boundaries and the signed extremes. Every character taken from the block is
// compared with text worked out on the bench side, under random gaps on the
// input and random stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module integer_to_decimal_ascii_test;
   import i2da_pkg::*;

   localparam int VALUE_BITS   = VALUE_BITS_DEF;
   localparam int RANDOM_ITEMS = 138;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 60;

   // One directed row; an empty text means the predictor supplies the text
   typedef struct {
      logic [IN_BITS-1:0] value;
      bit                 is_signed;
      string              text;
   } number_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_chars[$];
   string   typed_text_q[$];
   bit      steady_flow = 1'b1;
   int      stall_left = 0;
   int      failures = 0;
   int      numbers_sent = 0;
   int      negatives_sent = 0;
   int      chars_checked = 0;
   int      cycle_count = 0;
   rsp_type want;
   string   text;

   number_row_type directed_rows[] = '{
      '{32'h0000_0000, 1'b0, "0"},
      '{32'h0000_0000, 1'b1, "0"},
      '{32'h0000_0001, 1'b0, "1"},
      '{32'h0000_0009, 1'b1, "9"},
      '{32'h0000_000A, 1'b0, "10"},
      '{32'hFFFF_FFFF, 1'b0, "4294967295"},
      '{32'hFFFF_FFFF, 1'b1, "-1"},
      '{32'h8000_0000, 1'b1, "-2147483648"},
      '{32'h8000_0000, 1'b0, "2147483648"},
      '{32'h7FFF_FFFF, 1'b1, "2147483647"},
      '{32'h7FFF_FFFF, 1'b0, "2147483647"},
      '{32'h8000_0001, 1'b1, "-2147483647"},
      '{32'hFFFF_FFF6, 1'b1, "-10"},
      '{32'h3B9A_CA00, 1'b0, "1000000000"},
      '{32'h3B9A_C9FF, 1'b1, "999999999"},
      '{32'hEE6B_2800, 1'b0, "4000000000"},
      '{32'h5555_5555, 1'b1, ""},
      '{32'hAAAA_AAAA, 1'b1, ""},
      '{32'hAAAA_AAAA, 1'b0, ""},
      '{32'h0000_3039, 1'b1, ""},
      '{32'hC000_0000, 1'b1, ""},
      '{32'h0001_0000, 1'b0, ""}
   };

   integer_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Decimal text of one number: optional minus, digits without leading zeros
   function automatic string decimal_text(logic [IN_BITS-1:0] value, bit is_signed);
      logic [63:0] mask;
      logic [63:0] raw;
      logic [63:0] magnitude;
      bit          negative;
      mask      = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
      raw       = {{(64-IN_BITS){1'b0}}, value} & mask;
      negative  = is_signed && raw[VALUE_BITS-1];
      magnitude = negative ? ((~raw + 64'd1) & mask) : raw;
      return negative ? {"-", $sformatf("%0d", magnitude)} : $sformatf("%0d", magnitude);
   endfunction

   // One expected character per byte of text, last one marked
   function automatic void queue_text(string chars);
      rsp_type item;
      for (int i = 0; i < chars.len(); i++) begin
         item.text_char = chars.getc(i);
         item.last      = (i == chars.len() - 1);
         expected_chars.push_back(item);
      end
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 4);
      else
         return $urandom_range(10, 60);
   endfunction

   // Random number, weighted toward digit-count edges and the extremes
   function automatic req_type random_number();
      req_type     item;
      logic [31:0] power;
      item.is_signed = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: item.value = $urandom();
         4, 5:       item.value = $urandom_range(0, 999);
         6:          item.value = 32'h0 - $urandom_range(1, 999);
         7: begin
            power = 32'd1;
            repeat ($urandom_range(0, 9)) power = power * 32'd10;
            item.value = power - 32'd1 + $urandom_range(0, 2);
         end
         8:          item.value = 32'h8000_0000 + $urandom_range(0, 3) - 32'd2;
         default:    item.value = 32'hFFFF_FFFF - $urandom_range(0, 15);
      endcase
      return item;
   endfunction

   task automatic note_failure(string msg);
      failures++;
      if (failures <= 10)
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   // Present one number from a falling edge and hold it until accepted
   task automatic send_number(req_type item, string typed);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      typed_text_q.push_back(typed);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Output stall pattern
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap();
      end
   end

   // Accepted numbers become expected text; taken characters are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            text = typed_text_q.pop_front();
            if (text == "")
               text = decimal_text(req_data.value, req_data.is_signed);
            if (text.getc(0) == CHAR_MINUS)
               negatives_sent++;
            numbers_sent++;
            queue_text(text);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               note_failure($sformatf("char %02h last %b with nothing expected",
                                      rsp_data.text_char, rsp_data.last));
            end else begin
               want = expected_chars.pop_front();
               chars_checked++;
               if (rsp_data.text_char !== want.text_char || rsp_data.last !== want.last)
                  note_failure($sformatf("char %02h last %b, expected %02h last %b",
                                         rsp_data.text_char, rsp_data.last,
                                         want.text_char, want.last));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d characters outstanding",
                  cycle_count, expected_chars.size());
         $display("integer_to_decimal_ascii verification failed");
         $finish;
      end
   end

   initial begin
      req_type item;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table, back to back
      foreach (directed_rows[i]) begin
         item.value     = directed_rows[i].value;
         item.is_signed = directed_rows[i].is_signed;
         send_number(item, directed_rows[i].text);
      end

      // Random numbers; the first stretch and a later one run without idling
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady_flow = (n < 30) || (n >= 100 && n < 115);
         send_number(random_number(), "");
      end
      req_valid <= 1'b0;
      steady_flow = 1'b0;

      // Drain
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d numbers (%0d directed, %0d negative), checked %0d characters.",
               numbers_sent, directed_rows.size(), negatives_sent, chars_checked);
      $display("Failures seen: %0d, cycles run: %0d", failures, cycle_count);
      if (failures == 0)
         $display("integer_to_decimal_ascii verification clean");
      else
         $display("integer_to_decimal_ascii verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/i2da_pkg.sv
rtl/i2da_datapath.sv
rtl/i2da_ctrl.sv
rtl/integer_to_decimal_ascii.sv
dv/integer_to_decimal_ascii_test.sv
